// ----- rtl/mic_pkg.sv -----
`timescale 1ns / 1ps

package mic_pkg;

   localparam int DEFAULT_GAIN_FRAC_BITS = 12;
   localparam int DEFAULT_OUT_FRAC_BITS  = 16;

   localparam int WORD_W  = 16;
   localparam int MAG_W   = 17;
   localparam int OFFS_W  = 17;
   localparam int SUM_W   = 18;
   localparam int LSB_W   = 11;
   localparam int FIELD_W = 32;
   localparam int AXES    = 3;

   // quotient bits per divider cycle
   localparam int DIV_STEP = 4;

   localparam logic [LSB_W-1:0] LSB_KIND0 = 11'd30;
   localparam logic [LSB_W-1:0] LSB_KIND1 = 11'd1090;

   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_FINISH  = 2'd1,
      CMD_MEASURE = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUM,
      ST_FSTART,
      ST_FWAIT,
      ST_MUL,
      ST_CSTART,
      ST_CWAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic track;
      logic span;
      logic mag;
      logic mul;
      logic fin_start;
      logic fin_commit;
      logic corr_start;
   } lane_ctrl_type;

   typedef struct packed {
      logic                      busy;
      logic [WORD_W-1:0]         span;
      logic signed [FIELD_W-1:0] field;
   } lane_stat_type;

endpackage

// ----- rtl/mic_div.sv -----
`timescale 1ns / 1ps

module mic_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   import mic_pkg::*;

   localparam int STEPS_N = NUM_W / DIV_STEP;
   localparam int CNT_W   = $clog2(STEPS_N + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] count_ff;

   // restoring division, DIV_STEP quotient bits per cycle
   always_comb begin
      logic [DEN_W:0] sh;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         sh     = {rem_in, quo_in[NUM_W-1]};
         quo_in = {quo_in[NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            sh        = sh - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = sh[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_W'(STEPS_N);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (count_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = (count_ff != '0);
   assign quo  = quo_ff;

endmodule

// ----- rtl/mic_lane.sv -----
`timescale 1ns / 1ps

module mic_lane #(
   parameter int GAIN_FRAC_BITS = mic_pkg::DEFAULT_GAIN_FRAC_BITS,
   parameter int OUT_FRAC_BITS  = mic_pkg::DEFAULT_OUT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mic_pkg::lane_ctrl_type              ctrl,
   input  logic signed [mic_pkg::WORD_W-1:0]   word,
   input  logic                                calibrated,
   input  logic [mic_pkg::SUM_W-1:0]           sum,
   input  logic [mic_pkg::LSB_W-1:0]           lsb,
   output mic_pkg::lane_stat_type              stat
);
   import mic_pkg::*;

   localparam int GW     = (GAIN_FRAC_BITS + 1 > 16) ? GAIN_FRAC_BITS + 1 : 16;
   localparam int PW     = MAG_W + GW;
   localparam int TW     = PW + OUT_FRAC_BITS + 1;
   localparam int CNW    = TW - GAIN_FRAC_BITS - 1;
   localparam int FNW    = GAIN_FRAC_BITS + SUM_W + 1;
   localparam int RAW_NW = (CNW > FNW) ? CNW : FNW;
   localparam int DIV_NW = ((RAW_NW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int QXW    = (DIV_NW > 33) ? DIV_NW : 33;
   localparam int UNIT_GAIN_INT = (GAIN_FRAC_BITS >= 16) ? 65535 : (1 << GAIN_FRAC_BITS);
   localparam logic [WORD_W-1:0] UNIT_GAIN = WORD_W'(UNIT_GAIN_INT);

   logic signed [WORD_W-1:0] min_ff, max_ff;
   logic signed [OFFS_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0]        gain_ff, gain_in;
   logic [WORD_W-1:0]        span_ff, span_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [PW-1:0]            prod_ff, prod_in;

   logic [OFFS_W:0]   diff;
   logic [OFFS_W:0]   diff_neg;
   logic [GW-1:0]     gsel;
   logic [TW-1:0]     corr_t;
   logic [SUM_W-1:0]  den3;
   logic [FNW-1:0]    fin_num;
   logic [DIV_NW-1:0] div_num;
   logic [SUM_W-1:0]  div_den;
   logic              div_busy;
   logic [DIV_NW-1:0] div_quo;
   logic [QXW-1:0]    qx;
   logic signed [FIELD_W-1:0] field;
   logic [WORD_W-1:0] span_full;

   // min and max tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 16'sh7FFF;
         max_ff <= 16'sh8000;
      end else if (ctrl.fin_commit) begin
         min_ff <= 16'sh7FFF;
         max_ff <= 16'sh8000;
      end else if (ctrl.track) begin
         if (word < min_ff) begin
            min_ff <= word;
         end
         if (word > max_ff) begin
            max_ff <= word;
         end
      end
   end

   assign span_full = WORD_W'(OFFS_W'(max_ff) - OFFS_W'(min_ff));
   assign span_in   = span_full;
   assign offset_in = OFFS_W'(max_ff) + OFFS_W'(min_ff);

   // half-lsb difference, its magnitude, and the magnitude times the gain
   always_comb begin
      diff     = {word[WORD_W-1], word, 1'b0}
               - (calibrated ? {offset_ff[OFFS_W-1], offset_ff} : '0);
      diff_neg = '0 - diff;
      neg_in   = diff[OFFS_W];
      mag_in   = neg_in ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      gsel     = calibrated ? GW'(gain_ff) : (GW'(1) << GAIN_FRAC_BITS);
      prod_in  = PW'(mag_ff) * PW'(gsel);
   end

   // rounded numerators for the shared divider
   always_comb begin
      den3    = SUM_W'({span_ff, 1'b0}) + SUM_W'(span_ff);
      fin_num = (FNW'(sum) << GAIN_FRAC_BITS) + FNW'(den3 >> 1);
      corr_t  = (TW'(prod_ff) << OUT_FRAC_BITS) + (TW'(lsb) << GAIN_FRAC_BITS);
      if (ctrl.fin_start) begin
         div_num = DIV_NW'(fin_num);
         div_den = den3;
      end else begin
         div_num = DIV_NW'(corr_t[TW-1:GAIN_FRAC_BITS+1]);
         div_den = SUM_W'(lsb);
      end
   end

   mic_div #(
      .NUM_W(DIV_NW),
      .DEN_W(SUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(ctrl.fin_start | ctrl.corr_start),
      .num  (div_num),
      .den  (div_den),
      .busy (div_busy),
      .quo  (div_quo)
   );

   assign qx = QXW'(div_quo);

   always_comb begin
      if (span_ff == '0) begin
         gain_in = UNIT_GAIN;
      end else if (qx[QXW-1:16] != '0) begin
         gain_in = 16'hFFFF;
      end else begin
         gain_in = qx[15:0];
      end
      if (!neg_ff) begin
         field = (qx[QXW-1:31] != '0) ? 32'sh7FFFFFFF : $signed(qx[31:0]);
      end else if ((qx[QXW-1:32] != '0) || (qx[31] && (qx[30:0] != '0))) begin
         field = 32'sh80000000;
      end else begin
         field = $signed(32'd0 - qx[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         gain_ff   <= UNIT_GAIN;
      end else if (ctrl.fin_commit) begin
         offset_ff <= offset_in;
         gain_ff   <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.span) begin
         span_ff <= span_in;
      end
      if (ctrl.mag) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign stat.busy  = div_busy;
   assign stat.span  = span_ff;
   assign stat.field = field;

endmodule

// ----- rtl/magnetometer_iron_calibration.sv -----
`timescale 1ns / 1ps

// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req_cmd, req_byte0 .. req_byte5
// rsp      out  rsp_valid / rsp_stall   rsp_field_x/y/z, rsp_is_calibrated
// csr      in   csr_valid / csr_ready   csr_sensor_kind
//
// one item at a time; sample, unused and finish-without-sample items go through ST_EXEC only
// finish steps through ST_SUM, ST_FSTART and ST_FWAIT, measure through ST_MUL, ST_CSTART, ST_CWAIT and ST_OUT;
// each waits in its WAIT state for the 4-bit-per-cycle divider in each axis lane
// reset clears tracking, offsets and flags and sets the gains to unit gain
// a result waits in the output register while rsp_stall is high;
// the next item is taken meanwhile, a measure item then holds at its end

module magnetometer_iron_calibration #(
   parameter int GAIN_FRAC_BITS = mic_pkg::DEFAULT_GAIN_FRAC_BITS,
   parameter int OUT_FRAC_BITS  = mic_pkg::DEFAULT_OUT_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic [7:0]                         req_byte0,
   input  logic [7:0]                         req_byte1,
   input  logic [7:0]                         req_byte2,
   input  logic [7:0]                         req_byte3,
   input  logic [7:0]                         req_byte4,
   input  logic [7:0]                         req_byte5,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mic_pkg::FIELD_W-1:0] rsp_field_x,
   output logic signed [mic_pkg::FIELD_W-1:0] rsp_field_y,
   output logic signed [mic_pkg::FIELD_W-1:0] rsp_field_z,
   output logic                               rsp_is_calibrated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_sensor_kind
);
   import mic_pkg::*;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff;
   logic          kind_ff;
   logic signed [WORD_W-1:0] word_ff [AXES];
   logic signed [WORD_W-1:0] word_in [AXES];
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic          calibrated_ff, calibrated_in;
   logic          seen_ff, seen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic signed [FIELD_W-1:0] field_ff [AXES];
   logic          is_cal_ff;
   logic          accept;
   logic          any_busy;
   logic [LSB_W-1:0] lsb;
   lane_ctrl_type ctrl;
   lane_stat_type stat [AXES];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign lsb       = kind_ff ? LSB_KIND1 : LSB_KIND0;

   // big-endian words, second kind swaps y and z
   always_comb begin
      word_in[0] = $signed({req_byte0, req_byte1});
      word_in[1] = kind_ff ? $signed({req_byte4, req_byte5}) : $signed({req_byte2, req_byte3});
      word_in[2] = kind_ff ? $signed({req_byte2, req_byte3}) : $signed({req_byte4, req_byte5});
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         for (int a = 0; a < AXES; a++) begin
            word_ff[a] <= word_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_sensor_kind;
      end
   end

   genvar g;
   generate
      for (g = 0; g < AXES; g++) begin : g_lane
         mic_lane #(
            .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .word      (word_ff[g]),
            .calibrated(calibrated_ff),
            .sum       (sum_ff),
            .lsb       (lsb),
            .stat      (stat[g])
         );
      end
   endgenerate

   assign any_busy = stat[0].busy | stat[1].busy | stat[2].busy;
   assign sum_in   = SUM_W'(stat[0].span) + SUM_W'(stat[1].span) + SUM_W'(stat[2].span);

   always_comb begin
      state_in      = state_ff;
      ctrl          = '0;
      calibrated_in = calibrated_ff;
      seen_in       = seen_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_SAMPLE: begin
                  ctrl.track = 1'b1;
                  seen_in    = 1'b1;
               end
               CMD_FINISH: begin
                  if (seen_ff) begin
                     ctrl.span = 1'b1;
                     state_in  = ST_SUM;
                  end
               end
               CMD_MEASURE: begin
                  ctrl.mag = 1'b1;
                  state_in = ST_MUL;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SUM: begin
            state_in = ST_FSTART;
         end
         ST_FSTART: begin
            ctrl.fin_start = 1'b1;
            state_in       = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (!any_busy) begin
               ctrl.fin_commit = 1'b1;
               calibrated_in   = 1'b1;
               seen_in         = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_CSTART;
         end
         ST_CSTART: begin
            ctrl.corr_start = 1'b1;
            state_in        = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (!any_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         calibrated_ff <= 1'b0;
         seen_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         calibrated_ff <= calibrated_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (rsp_load) begin
         for (int a = 0; a < AXES; a++) begin
            field_ff[a] <= stat[a].field;
         end
         is_cal_ff <= calibrated_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_x       = field_ff[0];
   assign rsp_field_y       = field_ff[1];
   assign rsp_field_z       = field_ff[2];
   assign rsp_is_calibrated = is_cal_ff;

endmodule

// ----- rtl/mic_checker.sv -----
`timescale 1ns / 1ps

module mic_checker #(
   parameter int OUT_FRAC_BITS = mic_pkg::DEFAULT_OUT_FRAC_BITS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [mic_pkg::FIELD_W-1:0] rsp_field_x,
   input logic signed [mic_pkg::FIELD_W-1:0] rsp_field_y,
   input logic signed [mic_pkg::FIELD_W-1:0] rsp_field_z,
   input logic                               rsp_is_calibrated
);
   import mic_pkg::*;

   // largest raw reading over the smallest lsb per gauss, plus rounding
   localparam longint UNCAL_MAX = ((64'sd32768 << OUT_FRAC_BITS) / 30) + 1;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_field_x)
         && $stable(rsp_field_y) && $stable(rsp_field_z) && $stable(rsp_is_calibrated))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while another is at work");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item at work");

   a_uncal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_calibrated |->
         longint'(rsp_field_x) <= UNCAL_MAX && longint'(rsp_field_x) >= -UNCAL_MAX
         && longint'(rsp_field_y) <= UNCAL_MAX && longint'(rsp_field_y) >= -UNCAL_MAX
         && longint'(rsp_field_z) <= UNCAL_MAX && longint'(rsp_field_z) >= -UNCAL_MAX)
      else $error("uncalibrated field out of sensor range");

endmodule

bind magnetometer_iron_calibration mic_checker #(
   .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_mic_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_field_x      (rsp_field_x),
   .rsp_field_y      (rsp_field_y),
   .rsp_field_z      (rsp_field_z),
   .rsp_is_calibrated(rsp_is_calibrated)
);
